[hw/rtl/nrfd_pkg.sv]
// ----------------------------------------------------------------------------
// nrfd_pkg: shared types and constants of the response frame deframer
// Frame constants, status codes, header error codes and the queue entry.
// ----------------------------------------------------------------------------
package nrfd_pkg;

   // Frame layout
   localparam logic [7:0] START_CODE = 8'hFF;
   localparam logic [7:0] FRAME_ID   = 8'hD5;
   localparam logic [7:0] POSTAMBLE  = 8'h00;
   localparam logic [7:0] PREAMBLE   = 8'h00;
   localparam int         MIN_FRAME  = 8;

   // Byte position counter, saturating
   localparam int             POS_W   = 9;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // Queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Closing status codes
   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_SHORT        = 3'd1,
      STATUS_BAD_PREAMBLE = 3'd2,
      STATUS_BAD_LEN_SUM  = 3'd3,
      STATUS_BAD_ID       = 3'd4,
      STATUS_BAD_POSTAMBLE = 3'd5
   } status_type;

   // Header error seen so far
   typedef enum logic [1:0] {
      HDR_NONE     = 2'd0,
      HDR_PREAMBLE = 2'd1,
      HDR_LEN_SUM  = 2'd2
   } hdr_err_type;

   // One result waiting in the queue
   typedef struct packed {
      logic       is_status;
      logic [7:0] payload_byte;
      status_type status_code;
   } entry_type;

endpackage

[hw/rtl/nrfd_if.sv]
// ----------------------------------------------------------------------------
// nrfd_req_if / nrfd_rsp_if: request and result channels
// Valid/ready channels carrying received bytes in and results out.
// ----------------------------------------------------------------------------
interface nrfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       final_byte;

   modport source (output valid, output rx_byte, output final_byte, input ready);
   modport sink   (input valid, input rx_byte, input final_byte, output ready);
endinterface

interface nrfd_rsp_if;
   import nrfd_pkg::*;
   logic       valid;
   logic       ready;
   logic       is_status;
   logic [7:0] payload_byte;
   status_type status_code;

   modport source (output valid, output is_status, output payload_byte,
                   output status_code, input ready);
   modport sink   (input valid, input is_status, input payload_byte,
                   input status_code, output ready);
endinterface

[hw/rtl/nfc_response_frame_deframer.sv]
// ----------------------------------------------------------------------------
// nfc_response_frame_deframer: response frame checker
// Checks one received frame buffer byte by byte and emits payload bytes and
// a closing status for the buffer.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    rx_byte[7:0], final_byte
//   rsp      out  valid/ready    is_status, payload_byte[7:0], status_code[2:0]
//
// One byte per cycle is accepted unless the result queue is full; the
// classifier keeps all frame state in registers and updates it in the accepting cycle.
// A result passes the queue write, then the output register, before it is
// presented; a stalled output can hold it in the queue. Bytes that cause no
// result pass through the classifier only.
// req.ready drops only while the result queue is full (rsp stalled).
// Reset is synchronous and clears frame state, queue and output valid.
// ----------------------------------------------------------------------------
module nfc_response_frame_deframer #(
   parameter int QUEUE_DEPTH = nrfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   nrfd_req_if.sink    req,
   nrfd_rsp_if.source  rsp
);
   import nrfd_pkg::*;

   logic      push, pop, queue_full, queue_valid;
   entry_type push_entry, queue_entry;

   nrfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   nrfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .out_valid  (queue_valid),
      .out_entry  (queue_entry)
   );

   nrfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_entry (queue_entry),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

[hw/rtl/nrfd_front.sv]
// ----------------------------------------------------------------------------
// nrfd_front: byte classifier
// Tracks the position in the buffer, checks header fields and pushes payload
// bytes and the closing status into the result queue.
// ----------------------------------------------------------------------------
module nrfd_front (
   input  logic                clock,
   input  logic                reset,
   nrfd_req_if.sink            req,
   input  logic                queue_full,
   output logic                push,
   output nrfd_pkg::entry_type push_entry
);
   import nrfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   hdr_err_type      hdr_ff, hdr_in;
   logic             id_bad_ff, id_bad_in;
   logic             post_bad_ff, post_bad_in;

   logic             accept;
   logic [POS_W-1:0] len_ext;
   status_type       code;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   // stored length; every use of it lies past the length byte
   assign len_ext   = {1'b0, len_ff};

   // Header checks, position update and result selection
   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      hdr_in      = hdr_ff;
      id_bad_in   = id_bad_ff;
      post_bad_in = post_bad_ff;
      push        = 1'b0;
      push_entry  = '{is_status: 1'b0, payload_byte: 8'h00, status_code: STATUS_OK};
      code        = STATUS_OK;

      if (pos_ff <= POS_W'(1)) begin
         if (req.rx_byte != PREAMBLE && hdr_ff == HDR_NONE) hdr_in = HDR_PREAMBLE;
      end else if (pos_ff == POS_W'(2)) begin
         if (req.rx_byte != START_CODE && hdr_ff == HDR_NONE) hdr_in = HDR_PREAMBLE;
      end else if (pos_ff == POS_W'(3)) begin
         len_in = req.rx_byte;
      end else if (pos_ff == POS_W'(4)) begin
         // zero length counts as a bad length checksum
         if (hdr_ff == HDR_NONE &&
             ((len_ff + req.rx_byte) != 8'h00 || len_ff == 8'h00)) hdr_in = HDR_LEN_SUM;
      end else if (pos_ff == POS_W'(5)) begin
         id_bad_in = (req.rx_byte != FRAME_ID);
      end

      if (pos_ff >= POS_W'(5) && pos_ff == len_ext + POS_W'(6))
         post_bad_in = (req.rx_byte != POSTAMBLE);

      // closing status, in priority order
      if (pos_ff < POS_W'(MIN_FRAME - 1)) begin
         code = STATUS_SHORT;
      end else begin
         case (hdr_in)
            HDR_PREAMBLE: code = STATUS_BAD_PREAMBLE;
            HDR_LEN_SUM:  code = STATUS_BAD_LEN_SUM;
            default: begin
               if (pos_ff < len_ext + POS_W'(6)) code = STATUS_SHORT;
               else if (id_bad_in)               code = STATUS_BAD_ID;
               else if (post_bad_in)             code = STATUS_BAD_POSTAMBLE;
               else                              code = STATUS_OK;
            end
         endcase
      end

      if (req.final_byte) begin
         push       = accept;
         push_entry = '{is_status: 1'b1, payload_byte: 8'h00, status_code: code};
         pos_in      = '0;
         len_in      = '0;
         hdr_in      = HDR_NONE;
         id_bad_in   = 1'b0;
         post_bad_in = 1'b0;
      end else begin
         if (pos_ff != POS_MAX) pos_in = pos_ff + POS_W'(1);
         if (hdr_in == HDR_NONE && pos_ff >= POS_W'(6) && pos_ff <= len_ext + POS_W'(4)) begin
            push       = accept;
            push_entry = '{is_status: 1'b0, payload_byte: req.rx_byte,
                           status_code: STATUS_OK};
         end
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         hdr_ff      <= HDR_NONE;
         id_bad_ff   <= 1'b0;
         post_bad_ff <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         hdr_ff      <= hdr_in;
         id_bad_ff   <= id_bad_in;
         post_bad_ff <= post_bad_in;
      end
   end

endmodule

[hw/rtl/nrfd_queue.sv]
// ----------------------------------------------------------------------------
// nrfd_queue: result queue
// Small FIFO that decouples the classifier from the output stage.
// ----------------------------------------------------------------------------
module nrfd_queue #(
   parameter int DEPTH = nrfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nrfd_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                out_valid,
   output nrfd_pkg::entry_type out_entry
);
   import nrfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (do_push && !do_pop)      count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

[hw/rtl/nrfd_back.sv]
// ----------------------------------------------------------------------------
// nrfd_back: output stage
// Takes results from the queue into the output register and presents them.
// ----------------------------------------------------------------------------
module nrfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  nrfd_pkg::entry_type in_entry,
   output logic                pop,
   nrfd_rsp_if.source          rsp
);
   import nrfd_pkg::*;

   logic      valid_ff;
   entry_type data_ff;
   logic      load;

   assign load = !valid_ff || rsp.ready;
   assign pop  = load && in_valid;

   assign rsp.valid        = valid_ff;
   assign rsp.is_status    = data_ff.is_status;
   assign rsp.payload_byte = data_ff.payload_byte;
   assign rsp.status_code  = data_ff.status_code;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= in_entry;
   end

endmodule

[hw/rtl/nrfd_checker.sv]
// ----------------------------------------------------------------------------
// nrfd_checker: port checks of the deframer
// Checks result encoding and output stall behavior at the top level ports.
// ----------------------------------------------------------------------------
module nrfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_status,
   input logic [7:0] rsp_payload_byte,
   input logic [2:0] rsp_status_code
);
   import nrfd_pkg::*;

   // status codes stay within the defined set
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_code <= STATUS_BAD_POSTAMBLE)
      else $error("status code out of range");

   // payload results carry a zero status field
   a_payload_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_status |-> rsp_status_code == STATUS_OK)
      else $error("payload result with nonzero status");

   // status results carry a zero payload field
   a_status_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_status |-> rsp_payload_byte == 8'h00)
      else $error("status result with nonzero payload");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_status) &&
         $stable(rsp_payload_byte) && $stable(rsp_status_code))
      else $error("stalled result changed");

endmodule

bind nfc_response_frame_deframer nrfd_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_is_status    (rsp.is_status),
   .rsp_payload_byte (rsp.payload_byte),
   .rsp_status_code  (rsp.status_code)
);
